/* rtl/core/assert_macros.svh */
// assertion macros shared by the alu modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that a implies b on the same edge
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication failed");

// check that a implies b on the next edge
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle implication failed");

`endif

/* rtl/core/sfpa_pkg.sv */
// shared types and constants for the saturating fixed-point alu
// no dependencies
`timescale 1ns / 1ps
package sfpa_pkg;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  localparam logic [1:0] FMT_Q4_12  = 2'd0;
  localparam logic [1:0] FMT_Q16_16 = 2'd1;
  localparam logic [1:0] FMT_Q24_8  = 2'd2;
  localparam logic [1:0] FMT_Q48_16 = 2'd3;

  localparam logic signed [63:0] MAX16 = 64'sh7FFF;
  localparam logic signed [63:0] MIN16 = -64'sh8000;
  localparam logic signed [63:0] MAX32 = 64'sh7FFFFFFF;
  localparam logic signed [63:0] MIN32 = -64'sh80000000;
  localparam logic signed [63:0] MAX64 = 64'sh7FFFFFFFFFFFFFFF;
  localparam logic signed [63:0] MIN64 = 64'sh8000000000000000;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         format;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } item_t;

  function automatic logic signed [63:0] fmt_max(input logic [1:0] f);
    case (f)
      FMT_Q4_12:  fmt_max = MAX16;
      FMT_Q48_16: fmt_max = MAX64;
      default:    fmt_max = MAX32;
    endcase
  endfunction

  function automatic logic signed [63:0] fmt_min(input logic [1:0] f);
    case (f)
      FMT_Q4_12:  fmt_min = MIN16;
      FMT_Q48_16: fmt_min = MIN64;
      default:    fmt_min = MIN32;
    endcase
  endfunction

endpackage

/* rtl/core/sfpa_front.sv */
// front end: accepts items, sign-extends operands by format, feeds the queue
// depends on sfpa_pkg
`timescale 1ns / 1ps
module sfpa_front (
  input  logic                 start,
  input  logic [1:0]           action,
  input  logic [1:0]           format,
  input  logic signed [63:0]   operand_a,
  input  logic signed [63:0]   operand_b,
  input  logic                 q_full,
  output logic                 busy,
  output logic                 push,
  output sfpa_pkg::item_t      push_item
);
  import sfpa_pkg::*;

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    push_item.action = action;
    push_item.format = format;
    case (format)
      FMT_Q4_12: begin
        push_item.a = {{48{operand_a[15]}}, operand_a[15:0]};
        push_item.b = {{48{operand_b[15]}}, operand_b[15:0]};
      end
      FMT_Q48_16: begin
        push_item.a = operand_a;
        push_item.b = operand_b;
      end
      default: begin
        push_item.a = {{32{operand_a[31]}}, operand_a[31:0]};
        push_item.b = {{32{operand_b[31]}}, operand_b[31:0]};
      end
    endcase
  end

endmodule

/* rtl/core/sfpa_queue.sv */
// short fifo between the front end and the execution back end
// depends on sfpa_pkg
`timescale 1ns / 1ps
module sfpa_queue #(
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sfpa_pkg::item_t  push_item,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output sfpa_pkg::item_t  head
);
  import sfpa_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  item_t         mem [Depth];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;

  assign full  = (count == (AW + 1)'(Depth));
  assign empty = (count == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, full, !push)
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, empty, !pop)
  `ASSERT_NEXT(a_count_grows, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

/* rtl/core/sfpa_back.sv */
// back end: pipelined add, subtract, multiply and radix-2 divide with saturation
// depends on sfpa_pkg
`timescale 1ns / 1ps
module sfpa_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  sfpa_pkg::item_t     in_item,
  output logic                out_valid,
  output logic signed [63:0]  out_result
);
  import sfpa_pkg::*;
  `include "assert_macros.svh"

  // divider: 80-bit magnitude numerator, one quotient bit per stage, 80 stages
  localparam int NW = 80;
  localparam int NS = NW;
  // control line runs alongside the divider
  localparam int LAT = NS;

  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
  } bypass_t;

  typedef struct packed {
    logic        neg;
    logic [1:0]  format;
    logic [63:0] d;
    logic [NW-1:0] n;
    logic [NW-1:0] q;
    logic [64:0] r;
  } div_t;

  // ---------------- stage 0: classify and do simple ops
  logic               v0;
  logic [1:0]         act0;
  logic [1:0]         fmt0;
  bypass_t            bp0;
  bypass_t            bp0_next;
  div_t               dv0;
  logic [63:0]        mx0;
  logic [63:0]        my0;
  logic               mneg0;

  logic signed [64:0] sum_w;
  logic signed [63:0] mx_lim;
  logic signed [63:0] mn_lim;
  logic [63:0]        ma;
  logic [63:0]        mb;
  logic [NW-1:0]      num;
  logic               a_neg;
  logic               b_neg;

  always_comb begin
    mx_lim = fmt_max(in_item.format);
    mn_lim = fmt_min(in_item.format);
    a_neg  = in_item.a[63];
    b_neg  = in_item.b[63];
    ma     = a_neg ? 64'(-in_item.a) : 64'(in_item.a);
    mb     = b_neg ? 64'(-in_item.b) : 64'(in_item.b);
    if (in_item.action == ACT_SUB) begin
      sum_w = 65'(in_item.a) - 65'(in_item.b);
    end else begin
      sum_w = 65'(in_item.a) + 65'(in_item.b);
    end
    case (in_item.format)
      FMT_Q4_12:  num = NW'(ma) << 12;
      FMT_Q24_8:  num = NW'(ma) << 8;
      default:    num = NW'(ma) << 16;
    endcase
    bp0_next.done = 1'b0;
    bp0_next.res  = '0;
    case (in_item.action)
      ACT_ADD, ACT_SUB: begin
        bp0_next.done = 1'b1;
        if (sum_w > 65'(mx_lim)) begin
          bp0_next.res = mx_lim;
        end else if (sum_w < 65'(mn_lim)) begin
          bp0_next.res = mn_lim;
        end else begin
          bp0_next.res = sum_w[63:0];
        end
      end
      ACT_DIV: begin
        if (in_item.b == '0) begin
          bp0_next.done = 1'b1;
          bp0_next.res  = a_neg ? mn_lim : mx_lim;
        end else if (in_item.format == FMT_Q48_16) begin
          if (in_item.a > (MAX64 >>> 16)) begin
            bp0_next.done = 1'b1;
            bp0_next.res  = MAX64;
          end else if (in_item.a <= -(64'sd1 <<< 47)) begin
            bp0_next.done = 1'b1;
            bp0_next.res  = MIN64;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    act0        <= in_item.action;
    fmt0        <= in_item.format;
    mx0         <= ma;
    my0         <= mb;
    mneg0       <= a_neg ^ b_neg;
    bp0         <= bp0_next;
    dv0.neg     <= a_neg ^ b_neg;
    dv0.format  <= in_item.format;
    dv0.d       <= mb;
    dv0.n       <= num;
    dv0.q       <= '0;
    dv0.r       <= '0;
  end

  // ---------------- divider pipeline
  div_t dv [NS+1];
  assign dv[0] = dv0;

  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [64:0] rs;
    logic [64:0] rd;
    div_t        nx;
    always_comb begin
      rs   = {dv[s].r[63:0], dv[s].n[NW-1-s]};
      rd   = rs - {1'b0, dv[s].d};
      nx   = dv[s];
      nx.r = rd[64] ? rs : rd;
      nx.q = {dv[s].q[NW-2:0], !rd[64]};
    end
    always_ff @(posedge clk) begin
      dv[s+1] <= nx;
    end
  end

  logic signed [63:0] div_res;
  always_comb begin
    logic [NW-1:0] qm;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    qm = dv[NS].q;
    hi = fmt_max(dv[NS].format);
    lo = fmt_min(dv[NS].format);
    if (!dv[NS].neg) begin
      div_res = (qm > NW'(hi)) ? hi : 64'(qm);
    end else begin
      div_res = (qm > NW'($unsigned(-lo))) ? lo : 64'(-qm);
    end
  end

  // ---------------- multiplier: partials then combine
  logic [63:0] p00;
  logic [63:0] p01;
  logic [63:0] p10;
  logic [63:0] p11;
  logic        mneg1;
  logic [1:0]  fmt1;

  always_ff @(posedge clk) begin
    p00   <= 64'(mx0[31:0]) * 64'(my0[31:0]);
    p01   <= 64'(mx0[31:0]) * 64'(my0[63:32]);
    p10   <= 64'(mx0[63:32]) * 64'(my0[31:0]);
    p11   <= 64'(mx0[63:32]) * 64'(my0[63:32]);
    mneg1 <= mneg0;
    fmt1  <= fmt0;
  end

  logic [127:0] prod2;
  logic         mneg2;
  logic [1:0]   fmt2;
  always_ff @(posedge clk) begin
    prod2 <= {64'd0, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {p11, 64'd0};
    mneg2 <= mneg1;
    fmt2  <= fmt1;
  end

  logic signed [63:0] mul_res;
  always_comb begin
    logic [127:0] sh;
    logic [127:0] ceil_sh;
    logic [127:0] mg;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = fmt_max(fmt2);
    lo = fmt_min(fmt2);
    case (fmt2)
      FMT_Q4_12: begin
        sh = prod2 >> 12;
        ceil_sh = (prod2 + 128'hFFF) >> 12;
      end
      FMT_Q24_8: begin
        sh = prod2 >> 8;
        ceil_sh = (prod2 + 128'hFF) >> 8;
      end
      default: begin
        sh = prod2 >> 16;
        ceil_sh = (prod2 + 128'hFFFF) >> 16;
      end
    endcase
    // narrow formats floor, so a negative product rounds its magnitude up
    mg = (mneg2 && fmt2 != FMT_Q48_16) ? ceil_sh : sh;
    if (!mneg2) begin
      mul_res = (mg > 128'(hi)) ? hi : 64'(mg);
    end else begin
      mul_res = (mg > 128'($unsigned(-lo))) ? lo : 64'(-mg);
    end
  end

  // ---------------- bypass and control delay line
  typedef struct packed {
    logic    v;
    logic    is_mul;
    bypass_t bp;
  } ctl_t;

  ctl_t ctl [LAT+1];
  always_comb begin
    ctl[0].v      = v0;
    ctl[0].is_mul = (act0 == ACT_MUL);
    ctl[0].bp     = bp0;
  end

  for (genvar s = 0; s < LAT; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[s+1].v <= 1'b0;
      end else begin
        ctl[s+1].v <= ctl[s].v;
      end
      ctl[s+1].is_mul <= ctl[s].is_mul;
      ctl[s+1].bp     <= ctl[s].bp;
    end
  end

  // multiplier result is ready after the partial-product and combine registers; hold it to line up
  logic signed [63:0] mul_dly [NS-2];
  always_ff @(posedge clk) begin
    mul_dly[0] <= mul_res;
  end
  for (genvar s = 1; s < NS - 2; s++) begin : g_mdly
    always_ff @(posedge clk) begin
      mul_dly[s] <= mul_dly[s-1];
    end
  end

  // results are taken from dv[NS] and mul_dly[NS-3], both lined up with ctl[NS]
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl[NS].v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl[NS].bp.done) begin
      out_result <= ctl[NS].bp.res;
    end else if (ctl[NS].is_mul) begin
      out_result <= mul_dly[NS-3];
    end else begin
      out_result <= div_res;
    end
  end

  `ASSERT_NEXT(a_valid_follows, clk, rst, ctl[NS].v, out_valid)
  `ASSERT_NEXT(a_idle_follows, clk, rst, !ctl[NS].v, !out_valid)
  `ASSERT_IMPLIES(a_bypass_not_mul, clk, rst, ctl[NS].v && ctl[NS].bp.done, !ctl[NS].is_mul)

endmodule

/* rtl/core/saturating_fixed_point_alu_unit.sv */
// channel   signals                                   direction
// command   start, busy, action, format, operand_a/b  in
// result    done, result                              out
//
// one item per cycle while busy is low
// every result is lined up with the 80-stage radix-2 divider pipeline, one quotient bit a stage
// synchronous active-high reset clears the queue and all valid bits
// busy rises only if the four-entry queue fills; the back end never stalls
// results are strobed by done for one cycle and cannot be held off
// depends on sfpa_pkg, sfpa_front, sfpa_queue, sfpa_back
`timescale 1ns / 1ps
module saturating_fixed_point_alu_unit #(
  parameter int QueueDepth = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [1:0]         format,
  input  logic signed [63:0] operand_a,
  input  logic signed [63:0] operand_b,
  output logic               done,
  output logic signed [63:0] result
);
  import sfpa_pkg::*;

  logic  push;
  item_t push_item;
  logic  full;
  logic  empty;
  item_t head;
  logic  pop;

  sfpa_front u_front (
    .start     (start),
    .action    (action),
    .format    (format),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .q_full    (full),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  sfpa_queue #(.Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (full),
    .empty     (empty),
    .head      (head)
  );

  assign pop = !empty;

  sfpa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pop),
    .in_item    (head),
    .out_valid  (done),
    .out_result (result)
  );

endmodule
